// File: hw/rtl/esfj_pkg.sv
// ----------------------------------------------------------------------------
// esfj_pkg
// Shared types, constants and fixed-point helpers for the edge stretch
// force and stiffness pipeline.
// ----------------------------------------------------------------------------
package esfj_pkg;

  // pi/4 with 32 fraction bits
  localparam logic [31:0] PI4_Q32 = 32'hC90FDAA2;

  // field widths
  localparam int COORD_W  = 32;
  localparam int DIFF_W   = 33;   // B - A, and its magnitude
  localparam int LEN_W    = 35;   // integer square root of the squared length
  localparam int RAD_W    = 2 * LEN_W;
  localparam int E_W      = 48;
  localparam int DIAM_W   = 32;
  localparam int KS_PROD_W = 112; // E*pi/4 times D^2, before the fraction shift
  localparam int DIV_QB   = 33;   // quotient bits of every divider
  localparam int PROD_W   = 68;   // signed product width used by mulq

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_YOUNGS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAM   = 8'd1;

  // row and column of the six unique block entries: xx xy xz yy yz zz
  localparam int JAC_ROW [6] = '{0, 0, 0, 1, 1, 2};
  localparam int JAC_COL [6] = '{0, 1, 2, 1, 2, 2};

  typedef logic signed [31:0] q_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // sideband carried alongside the square root
  typedef struct packed {
    logic                       valid;
    logic [2:0]                 sgn;
    logic [2:0][DIFF_W-1:0]     mag;
    logic [COORD_W-1:0]         rest;
  } sqrt_side_t;

  // sideband carried alongside the dividers
  typedef struct packed {
    logic               valid;
    logic               degen;
    logic [2:0]         sgn;
    logic [LEN_W-1:0]   len;
    logic [COORD_W-1:0] rest;
  } div_side_t;

  // clamp to the signed 32-bit range
  function automatic q_t sat32(input prod_t v);
    prod_t smax;
    prod_t smin;
    smax = prod_t'(64'sh7FFF_FFFF);
    smin = -prod_t'(64'sh8000_0000);
    if (v > smax) return q_t'(32'h7FFF_FFFF);
    if (v < smin) return q_t'(32'h8000_0000);
    return q_t'(v[31:0]);
  endfunction

  // drop the fraction bits of a product, rounding toward zero, then clamp
  function automatic q_t mulq(input prod_t p, input int unsigned f);
    logic  neg;
    prod_t m;
    prod_t v;
    neg = p[PROD_W-1];
    m = neg ? -p : p;
    m = m >>> f;
    v = neg ? -m : m;
    return sat32(v);
  endfunction

  // signed multiply at full product width
  function automatic prod_t smul(input logic signed [DIFF_W-1:0] a,
                                 input logic signed [DIFF_W-1:0] b);
    prod_t aa;
    prod_t bb;
    aa = a;
    bb = b;
    return aa * bb;
  endfunction

endpackage

// File: hw/rtl/esfj_delay.sv
// ----------------------------------------------------------------------------
// esfj_delay
// Stallable delay line that carries sideband data next to a datapath unit.
// ----------------------------------------------------------------------------
module esfj_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [DEPTH];

  // shift on every advancing cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) taps[i] <= '0;
    end else if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// File: hw/rtl/esfj_isqrt.sv
// ----------------------------------------------------------------------------
// esfj_isqrt
// Pipelined integer square root, one root bit per stage (restoring method).
// ----------------------------------------------------------------------------
module esfj_isqrt #(
  parameter int ROOT_W = 35
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  localparam int IN_W = 2 * ROOT_W;
  localparam int R_W  = ROOT_W + 3;

  logic [R_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [IN_W-1:0]   rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [R_W-1:0]    rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [IN_W-1:0]   rad_i;
    logic [R_W-1:0]    rem2;
    logic [R_W-1:0]    trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
    end

    // bring down the next bit pair and test root*4+1
    always_comb begin
      rem2  = {rem_i[R_W-3:0], rad_i[IN_W-1 -: 2]};
      trial = R_W'({root_i, 2'b01});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem2 >= trial) begin
          rem_q[k]  <= rem2 - trial;
          root_q[k] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem2;
          root_q[k] <= {root_i[ROOT_W-2:0], 1'b0};
        end
        rad_q[k] <= rad_i << 2;
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

// File: hw/rtl/esfj_div.sv
// ----------------------------------------------------------------------------
// esfj_div
// Pipelined unsigned long division, one quotient bit per stage, with an
// overflow flag when the quotient does not fit in QB bits.
// ----------------------------------------------------------------------------
module esfj_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 35,
  parameter int QB    = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QB-1:0]    quo,
  output logic             ovf
);

  localparam int HW = NUM_W - QB;
  localparam int CW = (HW > DEN_W) ? HW : DEN_W;

  logic             e_ovf;
  logic [DEN_W-1:0] e_rem;
  logic [QB-1:0]    e_low;
  logic [DEN_W-1:0] e_den;

  // entry: the high part must be below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      e_ovf <= CW'(num[NUM_W-1:QB]) >= CW'(den);
      e_rem <= DEN_W'(num[NUM_W-1:QB]);
      e_low <= num[QB-1:0];
      e_den <= den;
    end
  end

  logic [DEN_W-1:0] rem_q [QB];
  logic [QB-1:0]    low_q [QB];
  logic [DEN_W-1:0] den_q [QB];
  logic [QB-1:0]    quo_q [QB];
  logic             ovf_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DEN_W-1:0] rem_i;
    logic [QB-1:0]    low_i;
    logic [DEN_W-1:0] den_i;
    logic [QB-1:0]    quo_i;
    logic             ovf_i;
    logic [DEN_W:0]   rem2;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_i = e_rem;
      assign low_i = e_low;
      assign den_i = e_den;
      assign quo_i = '0;
      assign ovf_i = e_ovf;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign low_i = low_q[k-1];
      assign den_i = den_q[k-1];
      assign quo_i = quo_q[k-1];
      assign ovf_i = ovf_q[k-1];
    end

    // one restoring step
    always_comb begin
      rem2 = {rem_i, low_i[QB-1]};
      diff = rem2 - {1'b0, den_i};
      ge   = rem2 >= {1'b0, den_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        quo_q[k] <= {quo_i[QB-2:0], ge};
        low_q[k] <= low_i << 1;
        den_q[k] <= den_i;
        ovf_q[k] <= ovf_i;
      end
    end
  end

  assign quo = quo_q[QB-1];
  assign ovf = ovf_q[QB-1];

endmodule

// File: hw/rtl/esfj_coef.sv
// ----------------------------------------------------------------------------
// esfj_coef
// Forms the stiffness numerator E*(pi/4)*D^2 from the configuration
// registers in a short free-running multiply pipeline.
// ----------------------------------------------------------------------------
module esfj_coef #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic [esfj_pkg::E_W-1:0]          youngs,
  input  logic [esfj_pkg::DIAM_W-1:0]       diam,
  output logic [esfj_pkg::KS_PROD_W-FRAC_BITS-1:0] num
);

  localparam int NUM_W = esfj_pkg::KS_PROD_W - FRAC_BITS;

  logic [63:0]  ep_lo;
  logic [47:0]  ep_hi;
  logic [63:0]  d2_c1;
  logic [47:0]  ep;
  logic [63:0]  d2_c2;
  logic [63:0]  p_ll;
  logic [63:0]  p_lh;
  logic [47:0]  p_hl;
  logic [47:0]  p_hh;
  logic [63:0]  lo_c4;
  logic [64:0]  mid_c4;
  logic [47:0]  hh_c4;
  logic [111:0] full;

  // E * pi/4 split in two products; D squared
  always_ff @(posedge clk) begin
    ep_lo <= 64'(youngs[31:0]) * 64'(esfj_pkg::PI4_Q32);
    ep_hi <= 48'(youngs[47:32]) * 48'(esfj_pkg::PI4_Q32);
    d2_c1 <= 64'(diam) * 64'(diam);
  end

  // drop the 32 fraction bits of pi/4
  always_ff @(posedge clk) begin
    ep    <= 48'(ep_hi + 48'(ep_lo[63:32]));
    d2_c2 <= d2_c1;
  end

  // partial products of ep * D^2
  always_ff @(posedge clk) begin
    p_ll <= 64'(ep[31:0]) * 64'(d2_c2[31:0]);
    p_lh <= 64'(ep[31:0]) * 64'(d2_c2[63:32]);
    p_hl <= 48'(ep[47:32]) * 48'(d2_c2[31:0]);
    p_hh <= 48'(ep[47:32]) * 48'(d2_c2[63:32]);
  end

  always_ff @(posedge clk) begin
    lo_c4  <= p_ll;
    mid_c4 <= 65'(p_lh) + 65'(p_hl);
    hh_c4  <= p_hh;
  end

  always_comb begin
    full = 112'(lo_c4) + (112'(mid_c4) << 32) + (112'(hh_c4) << 64);
  end

  always_ff @(posedge clk) begin
    num <= NUM_W'(full >> FRAC_BITS);
  end

endmodule

// File: hw/rtl/edge_stretch_force_jacobian.sv
// ----------------------------------------------------------------------------
// edge_stretch_force_jacobian
// Axial spring force and 3x3 stiffness block for one 3D edge per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one edge: node A xyz, node B xyz and rest length, all
//   Q16.16 by default. m_axis returns the node-A force and the six unique
//   entries of the symmetric stiffness block; tuser flags a zero-length edge,
//   in which case all data is zero. Node B force is the negated force and
//   the full 6x6 Jacobian is [[H,-H],[-H,H]].
//   The cfg channel writes Young's modulus (index 0) and rod diameter
//   (index 1); it is always ready. The user must write it only while no edge
//   is in flight; the block does not enforce this. Other indexes are ignored.
// Timing:
//   One edge per cycle while the receiver does not stall. The pipeline is
//   4 front stages, the 35-stage square root, the 34-stage dividers,
//   7 multiply/saturate stages and the output register.
// Reset and stalls:
//   rst clears all valid bits and restores both registers to 1.0. When the
//   receiver stalls, one more result lands in a skid register, then
//   s_axis_tready drops and the whole pipeline holds.
// ----------------------------------------------------------------------------
module edge_stretch_force_jacobian #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // node_a_x, node_a_y, node_a_z, node_b_x, node_b_y, node_b_z, rest_length
  input  logic [223:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // force_x, force_y, force_z, jac_xx, jac_xy, jac_xz, jac_yy, jac_yz, jac_zz
  output logic [287:0] m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [esfj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esfj_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW    = esfj_pkg::DIFF_W;
  localparam int LW    = esfj_pkg::LEN_W;
  localparam int QB    = esfj_pkg::DIV_QB;
  localparam int N_NW  = DW + FRAC_BITS;
  localparam int R_NW  = 32 + FRAC_BITS;
  localparam int KS_NW = esfj_pkg::KS_PROD_W - FRAC_BITS;
  localparam int DIV_LAT = QB + 1;

  logic en;

  // --------------------------------------------------------------------------
  // configuration registers
  logic [esfj_pkg::E_W-1:0]    youngs;
  logic [esfj_pkg::DIAM_W-1:0] diam;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      youngs <= esfj_pkg::E_W'(1) << FRAC_BITS;
      diam   <= esfj_pkg::DIAM_W'(1) << FRAC_BITS;
    end else if (cfg_valid) begin
      case (cfg_index)
        esfj_pkg::REG_YOUNGS: youngs <= cfg_data;
        esfj_pkg::REG_DIAM:   diam   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [KS_NW-1:0] ks_num;

  esfj_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
    .clk    (clk),
    .youngs (youngs),
    .diam   (diam),
    .num    (ks_num)
  );

  // --------------------------------------------------------------------------
  // front: difference, magnitude, squares, sum
  logic                 s0_v, s1_v, s2_v, s3_v;
  logic signed [DW-1:0] s0_d [3];
  logic [31:0]          s0_rest, s1_rest, s2_rest, s3_rest;
  logic [DW-1:0]        s1_mag [3];
  logic [2:0]           s1_sgn, s2_sgn, s3_sgn;
  logic [DW-1:0]        s2_mag [3];
  logic [DW-1:0]        s3_mag [3];
  logic [2*DW-1:0]      s2_sq [3];
  logic [2*DW+1:0]      s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s0_v <= s_axis_tvalid;
      s1_v <= s0_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_d[i] <= DW'($signed(s_axis_tdata[32*(i+3) +: 32]))
                 - DW'($signed(s_axis_tdata[32*i +: 32]));
        s1_mag[i] <= s0_d[i][DW-1] ? DW'(-s0_d[i]) : DW'(s0_d[i]);
        s1_sgn[i] <= s0_d[i][DW-1];
        s2_sq[i]  <= (2*DW)'(s1_mag[i]) * (2*DW)'(s1_mag[i]);
        s2_mag[i] <= s1_mag[i];
        s3_mag[i] <= s2_mag[i];
      end
      s0_rest <= s_axis_tdata[223:192];
      s1_rest <= s0_rest;
      s2_rest <= s1_rest;
      s3_rest <= s2_rest;
      s2_sgn  <= s1_sgn;
      s3_sgn  <= s2_sgn;
      s3_sum  <= (2*DW+2)'(s2_sq[0]) + (2*DW+2)'(s2_sq[1]) + (2*DW+2)'(s2_sq[2]);
    end
  end

  // --------------------------------------------------------------------------
  // square root with its sideband
  esfj_pkg::sqrt_side_t sq_in, sq_out;
  logic [LW-1:0]        len;

  always_comb begin
    sq_in.valid = s3_v;
    sq_in.sgn   = s3_sgn;
    for (int i = 0; i < 3; i++) sq_in.mag[i] = s3_mag[i];
    sq_in.rest  = s3_rest;
  end

  esfj_isqrt #(.ROOT_W(LW)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (esfj_pkg::RAD_W'(s3_sum)),
    .root (len)
  );

  esfj_delay #(.W($bits(esfj_pkg::sqrt_side_t)), .DEPTH(LW)) u_sq_side (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (sq_in),
    .dout (sq_out)
  );

  // --------------------------------------------------------------------------
  // dividers: direction, rest ratio, stiffness
  logic [QB-1:0]       n_quo [3];
  logic                n_ovf [3];
  logic [QB-1:0]       r_quo, ks_quo;
  logic                r_ovf, ks_ovf;
  esfj_pkg::div_side_t dv_in, dv_out;

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    esfj_div #(.NUM_W(N_NW), .DEN_W(LW), .QB(QB)) u_div (
      .clk (clk),
      .en  (en),
      .num ({sq_out.mag[i], FRAC_BITS'(0)}),
      .den (len),
      .quo (n_quo[i]),
      .ovf (n_ovf[i])
    );
  end

  esfj_div #(.NUM_W(R_NW), .DEN_W(LW), .QB(QB)) u_rdiv (
    .clk (clk),
    .en  (en),
    .num ({sq_out.rest, FRAC_BITS'(0)}),
    .den (len),
    .quo (r_quo),
    .ovf (r_ovf)
  );

  esfj_div #(.NUM_W(KS_NW), .DEN_W(LW), .QB(QB)) u_ksdiv (
    .clk (clk),
    .en  (en),
    .num (ks_num),
    .den (len),
    .quo (ks_quo),
    .ovf (ks_ovf)
  );

  always_comb begin
    dv_in.valid = sq_out.valid;
    dv_in.degen = (len == '0);
    dv_in.sgn   = sq_out.sgn;
    dv_in.len   = len;
    dv_in.rest  = sq_out.rest;
  end

  esfj_delay #(.W($bits(esfj_pkg::div_side_t)), .DEPTH(DIV_LAT)) u_dv_side (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (dv_in),
    .dout (dv_out)
  );

  // --------------------------------------------------------------------------
  // P0: signed direction, clamped stiffness, strain ratio, stretch
  esfj_pkg::q_t   n_next [3];
  esfj_pkg::q_t   ks_next, r_next, st_next;
  esfj_pkg::prod_t qv, one_q;
  esfj_pkg::q_t   p0_n [3];
  esfj_pkg::q_t   p0_ks, p0_r, p0_st;
  logic           p0_v, p0_deg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_next[i] = dv_out.sgn[i] ? -esfj_pkg::q_t'(n_quo[i][31:0])
                                :  esfj_pkg::q_t'(n_quo[i][31:0]);
    end
    ks_next = (ks_ovf || ks_quo[QB-1:31] != '0) ? esfj_pkg::q_t'(32'h7FFF_FFFF)
                                                : esfj_pkg::q_t'({1'b0, ks_quo[30:0]});
    qv      = r_ovf ? esfj_pkg::prod_t'({QB{1'b1}}) : esfj_pkg::prod_t'(r_quo);
    one_q   = esfj_pkg::prod_t'(1) <<< FRAC_BITS;
    r_next  = esfj_pkg::sat32(one_q - qv);
    st_next = esfj_pkg::sat32(esfj_pkg::prod_t'(dv_out.rest)
                              - esfj_pkg::prod_t'(dv_out.len));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_n   <= n_next;
      p0_ks  <= ks_next;
      p0_r   <= r_next;
      p0_st  <= st_next;
      p0_deg <= dv_out.degen;
    end
  end

  // --------------------------------------------------------------------------
  // M1..M6: products and their fraction shifts
  esfj_pkg::prod_t m1_pff, m3_pf [3], m3_prn [6], m5_pj [6];
  esfj_pkg::prod_t m1_pnn [6];
  esfj_pkg::q_t    m1_n [3], m2_n [3], m2_nn [6], m2_ff;
  esfj_pkg::q_t    m1_r, m2_r, m1_ks, m2_ks, m3_ks, m4_ks;
  esfj_pkg::q_t    m3_nn [6], m4_f [3], m4_h [6], m5_f [3];
  logic            m1_v, m2_v, m3_v, m4_v, m5_v, m6_v;
  logic            m1_deg, m2_deg, m3_deg, m4_deg, m5_deg, m6_deg;
  logic [287:0]    m6_data;
  logic signed [DW-1:0] id_k [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      m4_v <= 1'b0;
      m5_v <= 1'b0;
      m6_v <= 1'b0;
    end else if (en) begin
      p0_v <= dv_out.valid;
      m1_v <= p0_v;
      m2_v <= m1_v;
      m3_v <= m2_v;
      m4_v <= m3_v;
      m5_v <= m4_v;
      m6_v <= m5_v;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      id_k[k] = (esfj_pkg::JAC_ROW[k] == esfj_pkg::JAC_COL[k])
              ? (DW'(1) << FRAC_BITS) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // M1: ks*stretch and n n^T
      m1_pff <= esfj_pkg::smul(p0_ks, p0_st);
      for (int k = 0; k < 6; k++)
        m1_pnn[k] <= esfj_pkg::smul(p0_n[esfj_pkg::JAC_ROW[k]],
                                    p0_n[esfj_pkg::JAC_COL[k]]);
      m1_n   <= p0_n;
      m1_r   <= p0_r;
      m1_ks  <= p0_ks;
      m1_deg <= p0_deg;

      // M2: shift and clamp
      m2_ff <= esfj_pkg::mulq(m1_pff, FRAC_BITS);
      for (int k = 0; k < 6; k++) m2_nn[k] <= esfj_pkg::mulq(m1_pnn[k], FRAC_BITS);
      m2_n   <= m1_n;
      m2_r   <= m1_r;
      m2_ks  <= m1_ks;
      m2_deg <= m1_deg;

      // M3: force products and r*(I - n n^T)
      for (int i = 0; i < 3; i++) m3_pf[i] <= esfj_pkg::smul(m2_ff, m2_n[i]);
      for (int k = 0; k < 6; k++)
        m3_prn[k] <= esfj_pkg::smul(m2_r, id_k[k] - DW'(m2_nn[k]));
      m3_nn  <= m2_nn;
      m3_ks  <= m2_ks;
      m3_deg <= m2_deg;

      // M4: force values and the bracketed block
      for (int i = 0; i < 3; i++) m4_f[i] <= esfj_pkg::mulq(m3_pf[i], FRAC_BITS);
      for (int k = 0; k < 6; k++)
        m4_h[k] <= esfj_pkg::sat32(esfj_pkg::prod_t'(m3_nn[k])
                   + esfj_pkg::prod_t'(esfj_pkg::mulq(m3_prn[k], FRAC_BITS)));
      m4_ks  <= m3_ks;
      m4_deg <= m3_deg;

      // M5: scale by ks
      for (int k = 0; k < 6; k++) m5_pj[k] <= esfj_pkg::smul(m4_ks, m4_h[k]);
      m5_f   <= m4_f;
      m5_deg <= m4_deg;

      // M6: final shift, zero a degenerate edge, pack
      for (int i = 0; i < 3; i++)
        m6_data[32*i +: 32] <= m5_deg ? 32'd0 : m5_f[i];
      for (int k = 0; k < 6; k++)
        m6_data[32*(k+3) +: 32] <= m5_deg ? 32'd0
                                 : esfj_pkg::mulq(m5_pj[k], FRAC_BITS);
      m6_deg <= m5_deg;
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid stage
  logic [287:0] skid_data;
  logic         skid_deg;
  logic         skid_v;

  assign en            = !skid_v;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_v        <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_v) begin
        m_axis_tvalid <= 1'b1;
        skid_v        <= 1'b0;
      end else begin
        m_axis_tvalid <= m6_v;
      end
    end else if (m6_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= skid_v ? skid_data : m6_data;
      m_axis_tuser <= skid_v ? skid_deg  : m6_deg;
    end else if (en) begin
      skid_data <= m6_data;
      skid_deg  <= m6_deg;
    end
  end

endmodule

// File: hw/rtl/esfj_checker.sv
// ----------------------------------------------------------------------------
// esfj_checker
// Port-level checks for the edge stretch force pipeline, bound to the top.
// ----------------------------------------------------------------------------
module esfj_checker (
  input logic         clk,
  input logic         rst,
  input logic [223:0] s_axis_tdata,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [287:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [esfj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [esfj_pkg::CFG_DATA_W-1:0] cfg_data
);

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a zero-length edge carries all-zero force and stiffness
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate edge with nonzero data");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // input is refused only while an earlier result is still stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input refused without an output stall");

endmodule

bind edge_stretch_force_jacobian esfj_checker u_esfj_checker (.*);
